// ===== sv/ldh_pkg.sv =====
// ----------------------------------------------------------------------------
// ldh_pkg
// shared types and constants for the leading digit histogram unit
// ----------------------------------------------------------------------------
package ldh_pkg;

  localparam int unsigned CountBitsDefault = 32;
  localparam int unsigned NumBins = 10;
  localparam logic [3:0] RejectCode = 4'd10;
  localparam logic [53:0] SigLimit = 54'h20_0000_0000_0000;

  typedef enum logic [1:0] {
    CMD_COUNT  = 2'd0,
    CMD_REPORT = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] sample_bits;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  digit;
    logic [31:0] bin_count;
    logic        last;
  } out_item_t;

  // classified work passed from front to back
  typedef struct packed {
    cmd_t       command;
    logic [3:0] digit;
  } job_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_FRAC,
    FS_INT,
    FS_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_REPORT
  } back_state_t;

endpackage

// ===== sv/ldh_front.sv =====
// ----------------------------------------------------------------------------
// ldh_front
// accepts items, finds the leading decimal digit, pushes a job to the queue
// ----------------------------------------------------------------------------
module ldh_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ldh_pkg::in_item_t in_data,
  output logic              job_valid,
  input  logic              job_ready,
  output ldh_pkg::job_t     job_data
);

  ldh_pkg::front_state_t state_r, state_nxt;
  logic [63:0] sig_r, sig_nxt;          // integer value or fraction significand
  logic signed [12:0] exp_r, exp_nxt;
  ldh_pkg::job_t job_r, job_nxt;
  logic [4:0]  k_r, k_nxt;              // power of ten under test
  logic [3:0]  cnt_r, cnt_nxt;          // subtractions done at that power

  logic [10:0] biased;
  logic [51:0] frac;
  logic [6:0]  e_int;
  logic [63:0] int_val;
  logic [56:0] prod;
  logic [2:0]  sh;
  logic [52:0] q;
  logic [52:0] q_rnd;
  logic [53:0] q_inc;
  logic        rnd_up;
  logic [3:0]  rem_bits;
  logic [3:0]  half_bits;
  logic        ge_one;
  logic [63:0] ip;
  logic [12:0] nexp;
  logic [63:0] pow_k;

  // powers of ten that fit in 64 bits
  function automatic logic [63:0] pow10(logic [4:0] k);
    logic [63:0] p;
    unique case (k)
      5'd0:  p = 64'd1;
      5'd1:  p = 64'd10;
      5'd2:  p = 64'd100;
      5'd3:  p = 64'd1000;
      5'd4:  p = 64'd10000;
      5'd5:  p = 64'd100000;
      5'd6:  p = 64'd1000000;
      5'd7:  p = 64'd10000000;
      5'd8:  p = 64'd100000000;
      5'd9:  p = 64'd1000000000;
      5'd10: p = 64'd10000000000;
      5'd11: p = 64'd100000000000;
      5'd12: p = 64'd1000000000000;
      5'd13: p = 64'd10000000000000;
      5'd14: p = 64'd100000000000000;
      5'd15: p = 64'd1000000000000000;
      5'd16: p = 64'd10000000000000000;
      5'd17: p = 64'd100000000000000000;
      5'd18: p = 64'd1000000000000000000;
      5'd19: p = 64'd10000000000000000000;
      default: p = 64'd0;
    endcase
    return p;
  endfunction

  assign biased = in_data.sample_bits[62:52];
  assign frac   = in_data.sample_bits[51:0];
  assign e_int  = 7'(biased - 11'd1023);
  assign int_val = (e_int >= 7'd52) ? (64'({1'b1, frac}) << (e_int - 7'd52))
                                    : (64'({1'b1, frac}) >> (7'd52 - e_int));
  assign pow_k = pow10(k_r);

  // value >= 1 check on sig * 2^exp
  always_comb begin
    nexp = -exp_r;
    if (!exp_r[12]) ge_one = (sig_r != 64'd0);
    else if (nexp >= 13'd64) ge_one = 1'b0;
    else ge_one = ((sig_r >> nexp[5:0]) != 64'd0);
    if (!exp_r[12]) ip = sig_r;
    else if (nexp >= 13'd64) ip = 64'd0;
    else ip = sig_r >> nexp[5:0];
  end

  // one times-ten step with round to 53 bits, nearest even
  always_comb begin
    prod = 57'(sig_r[52:0]) * 57'd10;
    if (prod[56]) sh = 3'd4;
    else if (prod[55]) sh = 3'd3;
    else if (prod[54]) sh = 3'd2;
    else if (prod[53]) sh = 3'd1;
    else sh = 3'd0;
    q = 53'(prod >> sh);
    rem_bits = 4'(prod) & 4'((5'd1 << sh) - 5'd1);
    half_bits = (sh == 3'd0) ? 4'd0 : 4'(5'd1 << (sh - 3'd1));
    rnd_up = (sh != 3'd0) &&
             ((rem_bits > half_bits) || (rem_bits == half_bits && q[0]));
    q_inc = 54'(q) + 54'(rnd_up);
    q_rnd = q_inc[53] ? q_inc[53:1] : q_inc[52:0];
  end

  always_comb begin
    state_nxt = state_r;
    sig_nxt   = sig_r;
    exp_nxt   = exp_r;
    job_nxt   = job_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    in_ready  = (state_r == ldh_pkg::FS_IDLE);
    job_valid = (state_r == ldh_pkg::FS_PUSH);
    unique case (state_r)
      ldh_pkg::FS_IDLE: begin
        if (in_valid) begin
          job_nxt.command = ldh_pkg::cmd_t'(in_data.command);
          job_nxt.digit   = 4'd0;
          state_nxt = ldh_pkg::FS_PUSH;
          if (in_data.command == ldh_pkg::CMD_COUNT) begin
            priority if (biased == 11'h7FF) job_nxt.digit = ldh_pkg::RejectCode;
            else if (biased == 11'd0 && frac == 52'd0) job_nxt.digit = 4'd0;
            else if (biased >= 11'd1023) begin
              if (biased >= 11'd1087) job_nxt.digit = ldh_pkg::RejectCode;
              else begin
                sig_nxt = int_val;
                k_nxt = 5'd19;
                cnt_nxt = 4'd0;
                state_nxt = ldh_pkg::FS_INT;
              end
            end else if (biased == 11'd0) begin
              sig_nxt = 64'(frac);
              exp_nxt = -13'sd1074;
              state_nxt = ldh_pkg::FS_FRAC;
            end else begin
              sig_nxt = 64'({1'b1, frac});
              exp_nxt = 13'(signed'({2'b0, biased})) - 13'sd1075;
              state_nxt = ldh_pkg::FS_FRAC;
            end
          end
        end
      end
      ldh_pkg::FS_FRAC: begin
        if (ge_one) begin
          job_nxt.digit = (ip > 64'd9) ? 4'd9 : 4'(ip);
          state_nxt = ldh_pkg::FS_PUSH;
        end else if (prod >= 57'(ldh_pkg::SigLimit)) begin
          sig_nxt = 64'(q_rnd);
          exp_nxt = exp_r + 13'(sh) + 13'(q_inc[53]);
        end else begin
          sig_nxt = 64'(prod);
        end
      end
      ldh_pkg::FS_INT: begin
        // walk down to the largest power of ten not above the value,
        // then count how many times it fits: that count is the digit
        if (sig_r >= pow_k) begin
          sig_nxt = sig_r - pow_k;
          cnt_nxt = cnt_r + 4'd1;
        end else if (cnt_r != 4'd0) begin
          job_nxt.digit = cnt_r;
          state_nxt = ldh_pkg::FS_PUSH;
        end else begin
          k_nxt = k_r - 5'd1;
        end
      end
      ldh_pkg::FS_PUSH: begin
        if (job_ready) state_nxt = ldh_pkg::FS_IDLE;
      end
      default: state_nxt = ldh_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ldh_pkg::FS_IDLE;
    else state_r <= state_nxt;
    sig_r <= sig_nxt;
    exp_r <= exp_nxt;
    job_r <= job_nxt;
    k_r   <= k_nxt;
    cnt_r <= cnt_nxt;
  end

  assign job_data = job_r;

endmodule

// ===== sv/ldh_queue.sv =====
// ----------------------------------------------------------------------------
// ldh_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module ldh_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  ldh_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output ldh_pkg::job_t rd_data
);

  ldh_pkg::job_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) mem_r[wp_r] <= wr_data;
  end

endmodule

// ===== sv/ldh_back.sv =====
// ----------------------------------------------------------------------------
// ldh_back
// bin store update, report walk and output register
// ----------------------------------------------------------------------------
module ldh_back #(
  parameter int unsigned COUNT_BITS = ldh_pkg::CountBitsDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  ldh_pkg::job_t      job_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ldh_pkg::out_item_t out_data
);

  logic [COUNT_BITS-1:0] bins_r [ldh_pkg::NumBins];
  ldh_pkg::back_state_t state_r, state_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic out_valid_r;
  ldh_pkg::out_item_t out_r;
  logic slot_free;
  logic out_load;
  logic [COUNT_BITS-1:0] cur, inc;
  logic [63:0] cur_w;

  assign slot_free = !out_valid_r || out_ready;
  assign cur = bins_r[job_data.digit];
  assign inc = (&cur) ? cur : cur + COUNT_BITS'(1);
  // a new item enters the output register this cycle
  assign out_load = (state_r == ldh_pkg::BS_IDLE && job_valid && slot_free &&
                     job_data.command == ldh_pkg::CMD_COUNT) ||
                    (state_r == ldh_pkg::BS_REPORT && slot_free);

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    job_ready = 1'b0;
    unique case (state_r)
      ldh_pkg::BS_IDLE: begin
        if (job_valid && slot_free) begin
          if (job_data.command == ldh_pkg::CMD_REPORT) begin
            state_nxt = ldh_pkg::BS_REPORT;
            idx_nxt = 4'd0;
          end else job_ready = 1'b1;
        end
      end
      ldh_pkg::BS_REPORT: begin
        if (slot_free) begin
          idx_nxt = idx_r + 4'd1;
          if (idx_r == 4'(ldh_pkg::NumBins - 1)) begin
            job_ready = 1'b1;
            state_nxt = ldh_pkg::BS_IDLE;
          end
        end
      end
      default: state_nxt = ldh_pkg::BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ldh_pkg::BS_IDLE;
      out_valid_r <= 1'b0;
      idx_r <= 4'd0;
      for (int i = 0; i < ldh_pkg::NumBins; i++) bins_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (state_r == ldh_pkg::BS_IDLE && job_valid && slot_free) begin
        unique case (job_data.command)
          ldh_pkg::CMD_COUNT: begin
            out_r.last <= 1'b1;
            out_r.digit <= job_data.digit;
            if (job_data.digit == ldh_pkg::RejectCode) out_r.bin_count <= 32'd0;
            else begin
              bins_r[job_data.digit] <= inc;
              out_r.bin_count <= 32'(64'(inc));
            end
          end
          ldh_pkg::CMD_CLEAR:
            for (int i = 0; i < ldh_pkg::NumBins; i++) bins_r[i] <= '0;
          ldh_pkg::CMD_REPORT, ldh_pkg::CMD_NONE: ;
          default: ;
        endcase
      end
      if (state_r == ldh_pkg::BS_REPORT && slot_free) begin
        out_r.digit <= idx_r;
        out_r.bin_count <= cur_w[31:0];
        out_r.last <= (idx_r == 4'(ldh_pkg::NumBins - 1));
      end
    end
  end

  assign cur_w = 64'(bins_r[idx_r]);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule

// ===== sv/leading_digit_histogram_unit.sv =====
// ----------------------------------------------------------------------------
// leading_digit_histogram_unit
// leading decimal digit histogram of double-precision samples
// ----------------------------------------------------------------------------
// usage:
// - in channel (in_valid/in_ready/in_data) takes a command and a 64-bit
//   double bit pattern; count gives one item, report gives ten (bins 0..9,
//   last on bin 9), clear and the unused command give none
// - out channel (out_valid/out_ready/out_data) carries digit, count, last
// - the front takes one item at a time: a fraction below one needs one
//   times-ten step per cycle, an integer one power-of-ten compare or
//   subtract per cycle
// - a two-entry job queue lets the front classify while the back drains
// - a count result passes the front, the job queue and the output register;
//   a report streams one bin per cycle while out_ready is high
// - reset zeroes all bins and empties the queue and output register
// - when the receiver stalls, the output register holds and the queue
//   fills, after which in_ready stays low
module leading_digit_histogram_unit #(
  parameter int unsigned COUNT_BITS = ldh_pkg::CountBitsDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ldh_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ldh_pkg::out_item_t out_data
);

  // front to queue
  logic          fq_valid, fq_ready;
  ldh_pkg::job_t fq_data;
  // queue to back
  logic          qb_valid, qb_ready;
  ldh_pkg::job_t qb_data;

  ldh_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .job_valid(fq_valid), .job_ready(fq_ready), .job_data(fq_data)
  );

  ldh_queue u_queue (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
  );

  ldh_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk, .rst_n,
    .job_valid(qb_valid), .job_ready(qb_ready), .job_data(qb_data),
    .out_valid, .out_ready, .out_data
  );

endmodule

// ===== sv/ldh_checker.sv =====
// ----------------------------------------------------------------------------
// ldh_port_checker
// port-level checks for the leading digit histogram unit
// ----------------------------------------------------------------------------
module ldh_port_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input ldh_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input ldh_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("out item changed while stalled");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.digit <= ldh_pkg::RejectCode)
    else $error("digit out of range");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.digit == ldh_pkg::RejectCode |->
      out_data.bin_count == 32'd0 && out_data.last)
    else $error("rejected item with count");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind leading_digit_histogram_unit ldh_port_checker u_ldh_checker (
  .clk, .rst_n, .in_valid, .in_ready, .in_data,
  .out_valid, .out_ready, .out_data
);
